@@ hw/rtl/fdre_pkg.sv @@
// Shared types and constants for the frame delta run encoder.
package fdre_pkg;

    // Reference store size and the widths that follow from it.
    localparam int unsigned MAX_FRAME_WORDS = 524288;
    localparam int unsigned ADDR_W          = $clog2(MAX_FRAME_WORDS);
    localparam int unsigned CNT_W           = $clog2(MAX_FRAME_WORDS + 1);

    // Fixed field widths.
    localparam int unsigned CFG_W   = 20;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned RUN_W   = 22;
    localparam int unsigned TOTAL_W = 23;
    localparam int unsigned CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // Byte accounting: each data word is four bytes, a run header is two words.
    localparam int unsigned BYTES_PER_WORD = 4;
    localparam int unsigned RUN_HDR_BYTES  = 2 * BYTES_PER_WORD;

    // Command carried in s_tuser.
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_ENCODE = 1'b1
    } cmd_t;

    // Record kind carried in m_tuser.
    typedef enum logic [1:0] {
        KIND_OFFSET = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_LENGTH = 2'd2,
        KIND_TOTAL  = 2'd3
    } kind_t;

    // One accepted word with its frame position.
    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] idx;
        logic              last;
    } item_t;

endpackage

@@ hw/rtl/fdre_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fdre_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while rd_en is low.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/fdre_index.sv @@
// Frame length register and word index tracking for the frame delta run encoder.
module fdre_index (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_write,
    input  logic [fdre_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         take,
    input  logic [fdre_pkg::WORD_W-1:0]  word_in,
    input  logic                         cmd_in,
    output fdre_pkg::item_t              item
);

    logic [fdre_pkg::CFG_W-1:0]  frame_words_reg;
    logic [fdre_pkg::ADDR_W-1:0] word_index_reg;
    logic [fdre_pkg::ADDR_W-1:0] word_index_next;
    logic [fdre_pkg::ADDR_W-1:0] idx;
    logic [fdre_pkg::CMP_W-1:0]  fw_ext;
    logic [fdre_pkg::CMP_W-1:0]  eff_words;
    logic [fdre_pkg::CMP_W-1:0]  last_idx;
    logic                        last_word;

    // Frame length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_words_reg <= fdre_pkg::CFG_W'(fdre_pkg::MAX_FRAME_WORDS);
        end else if (cfg_write) begin
            frame_words_reg <= cfg_data;
        end
    end

    // Effective frame length: zero acts as one, oversize acts as the store size.
    always_comb begin
        fw_ext = fdre_pkg::CMP_W'(frame_words_reg);
        if (fw_ext == '0) begin
            eff_words = fdre_pkg::CMP_W'(1);
        end else if (fw_ext > fdre_pkg::CMP_W'(fdre_pkg::MAX_FRAME_WORDS)) begin
            eff_words = fdre_pkg::CMP_W'(fdre_pkg::MAX_FRAME_WORDS);
        end else begin
            eff_words = fw_ext;
        end
        last_idx = eff_words - fdre_pkg::CMP_W'(1);
    end

    // Current position, clamped to the store, and the end-of-frame decision.
    always_comb begin
        if (fdre_pkg::CMP_W'(word_index_reg) > fdre_pkg::CMP_W'(fdre_pkg::MAX_FRAME_WORDS - 1)) begin
            idx = fdre_pkg::ADDR_W'(fdre_pkg::MAX_FRAME_WORDS - 1);
        end else begin
            idx = word_index_reg;
        end
        last_word       = (fdre_pkg::CMP_W'(idx) >= last_idx);
        word_index_next = last_word ? '0 : idx + fdre_pkg::ADDR_W'(1);
    end

    // The index advances on every accepted transfer, load or encode alike.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_index_reg <= '0;
        end else if (take) begin
            word_index_reg <= word_index_next;
        end
    end

    assign item.cmd  = fdre_pkg::cmd_t'(cmd_in);
    assign item.word = word_in;
    assign item.idx  = idx;
    assign item.last = last_word;

endmodule

@@ hw/rtl/fdre_encode.sv @@
// Compare stage, run accounting and result register of the frame delta run encoder.
module fdre_encode (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  fdre_pkg::item_t              item_in,
    output logic                         in_ready,
    input  logic [fdre_pkg::WORD_W-1:0]  ref_data,
    output logic                         wr_en,
    output logic [fdre_pkg::ADDR_W-1:0]  wr_addr,
    output logic [fdre_pkg::WORD_W-1:0]  wr_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fdre_pkg::WORD_W-1:0]  m_tdata,
    output logic [1:0]                   m_tuser,
    output logic                         m_tlast
);

    // Stage registers.
    logic                          b_valid_reg;
    fdre_pkg::item_t               b_item_reg;
    logic                          byp_hit_reg;
    logic [fdre_pkg::WORD_W-1:0]   byp_data_reg;
    logic [3:0]                    sent_reg;
    logic [3:0]                    sent_next;

    // Run state.
    logic                          in_run_reg;
    logic                          in_run_next;
    logic [fdre_pkg::RUN_W-1:0]    run_bytes_reg;
    logic [fdre_pkg::RUN_W-1:0]    run_bytes_next;
    logic [fdre_pkg::TOTAL_W-1:0]  total_reg;
    logic [fdre_pkg::TOTAL_W-1:0]  total_next;

    // Result register.
    logic                          m_valid_reg;
    logic [fdre_pkg::WORD_W-1:0]   m_value_reg;
    fdre_pkg::kind_t               m_kind_reg;
    logic                          m_last_reg;

    logic [fdre_pkg::WORD_W-1:0]   ref_word;
    logic                          is_enc;
    logic                          changed;
    logic [3:0]                    need;
    logic [3:0]                    pending;
    logic [3:0]                    sel_mask;
    fdre_pkg::kind_t               sel_kind;
    logic                          out_free;
    logic                          emit;
    logic                          done;
    logic [fdre_pkg::RUN_W-1:0]    run_after;
    logic [fdre_pkg::TOTAL_W-1:0]  total_after;
    logic [fdre_pkg::WORD_W-1:0]   sel_value;

    // A write that retires on the same edge as a read to the same entry is forwarded.
    assign ref_word = byp_hit_reg ? byp_data_reg : ref_data;

    // Compare and decide which records this word produces.
    always_comb begin
        is_enc  = (b_item_reg.cmd == fdre_pkg::CMD_ENCODE);
        changed = is_enc && (ref_word != b_item_reg.word);
        need[fdre_pkg::KIND_OFFSET] = changed && !in_run_reg;
        need[fdre_pkg::KIND_DATA]   = changed;
        need[fdre_pkg::KIND_LENGTH] = is_enc && ((changed && b_item_reg.last)
                                                 || (!changed && in_run_reg));
        need[fdre_pkg::KIND_TOTAL]  = is_enc && b_item_reg.last;
        pending = b_valid_reg ? (need & ~sent_reg) : 4'b0000;
    end

    // Byte counts after this word.
    always_comb begin
        run_after = (in_run_reg ? run_bytes_reg : '0)
                    + fdre_pkg::RUN_W'(fdre_pkg::BYTES_PER_WORD);
        if (!changed) begin
            total_after = total_reg;
        end else if (in_run_reg) begin
            total_after = total_reg + fdre_pkg::TOTAL_W'(fdre_pkg::BYTES_PER_WORD);
        end else begin
            total_after = total_reg + fdre_pkg::TOTAL_W'(fdre_pkg::RUN_HDR_BYTES
                                                         + fdre_pkg::BYTES_PER_WORD);
        end
    end

    // Pick the first record still owed, in record order.
    always_comb begin
        if (pending[fdre_pkg::KIND_OFFSET]) begin
            sel_kind = fdre_pkg::KIND_OFFSET;
        end else if (pending[fdre_pkg::KIND_DATA]) begin
            sel_kind = fdre_pkg::KIND_DATA;
        end else if (pending[fdre_pkg::KIND_LENGTH]) begin
            sel_kind = fdre_pkg::KIND_LENGTH;
        end else begin
            sel_kind = fdre_pkg::KIND_TOTAL;
        end
        sel_mask = 4'b0001 << sel_kind;

        case (sel_kind)
            fdre_pkg::KIND_OFFSET: sel_value = fdre_pkg::WORD_W'({b_item_reg.idx, 2'b00});
            fdre_pkg::KIND_DATA:   sel_value = b_item_reg.word;
            fdre_pkg::KIND_LENGTH: sel_value = changed ? fdre_pkg::WORD_W'(run_after)
                                                       : fdre_pkg::WORD_W'(run_bytes_reg);
            default:               sel_value = fdre_pkg::WORD_W'(total_after);
        endcase
    end

    // Handshake control: the word retires with its last record or at once if it has none.
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        emit     = (pending != 4'b0000) && out_free;
        done     = b_valid_reg && ((pending == 4'b0000)
                                   || (emit && ((pending & ~sel_mask) == 4'b0000)));
        in_ready = !b_valid_reg || done;

        if (take || done) begin
            sent_next = 4'b0000;
        end else if (emit) begin
            sent_next = sent_reg | sel_mask;
        end else begin
            sent_next = sent_reg;
        end
    end

    // Run state after the word retires.
    always_comb begin
        if (!is_enc) begin
            in_run_next    = 1'b0;
            run_bytes_next = '0;
            total_next     = '0;
        end else begin
            in_run_next    = changed && !b_item_reg.last;
            run_bytes_next = (changed && !b_item_reg.last) ? run_after : '0;
            total_next     = b_item_reg.last ? '0 : total_after;
        end
    end

    // The retiring word always goes back to the reference store.
    assign wr_en   = done;
    assign wr_addr = b_item_reg.idx;
    assign wr_data = b_item_reg.word;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            sent_reg      <= 4'b0000;
            in_run_reg    <= 1'b0;
            run_bytes_reg <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            sent_reg <= sent_next;
            if (take) begin
                b_valid_reg <= 1'b1;
            end else if (done) begin
                b_valid_reg <= 1'b0;
            end
            if (done) begin
                in_run_reg    <= in_run_next;
                run_bytes_reg <= run_bytes_next;
                total_reg     <= total_next;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (take) begin
            b_item_reg   <= item_in;
            byp_hit_reg  <= wr_en && (wr_addr == item_in.idx);
            byp_data_reg <= wr_data;
        end
        if (emit) begin
            m_value_reg <= sel_value;
            m_kind_reg  <= sel_kind;
            m_last_reg  <= (sel_kind == fdre_pkg::KIND_TOTAL);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ hw/rtl/frame_delta_run_encoder_top.sv @@
// Frame delta run encoder: top level joining index, reference store and encoder.
//
// The block takes one 32-bit frame word per transfer and compares it with the
// word at the same position in a 524288-entry reference store, then emits run
// offset, data, run length and frame total records. A word is accepted in the
// cycle after the previous one when that word produces at most one record and
// the output does not stall; a word that produces more records holds the input
// until its last record enters the result register, one record at a time. The
// reference store is read at acceptance and written when the word retires,
// with forwarding when both hit the same entry. The store has no clearing pass:
// frames must be loaded with the load command before they are encoded. The frame
// length register is written through the cfg port, which is always ready, and
// must only be written while no word is in flight.
module frame_delta_run_encoder_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: frame length in words.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fdre_pkg::CFG_W-1:0]   cfg_data,
    // Input words.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fdre_pkg::WORD_W-1:0]  s_tdata,   // [31:0] pixel_word
    input  logic                         s_tuser,   // [0] command
    // Output records.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [fdre_pkg::WORD_W-1:0]  m_tdata,   // [31:0] record_value
    output logic [1:0]                   m_tuser,   // [1:0] record_kind
    output logic                         m_tlast    // frame_last
);

    fdre_pkg::item_t              item;
    logic                         take;
    logic                         enc_ready;
    logic [fdre_pkg::WORD_W-1:0]  ref_data;
    logic                         wr_en;
    logic [fdre_pkg::ADDR_W-1:0]  wr_addr;
    logic [fdre_pkg::WORD_W-1:0]  wr_data;

    // Input transfer control.
    assign cfg_ready = 1'b1;
    assign s_tready  = enc_ready;
    assign take      = s_tvalid && enc_ready;

    // Frame length and word position.
    fdre_index u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .word_in   (s_tdata),
        .cmd_in    (s_tuser),
        .item      (item)
    );

    // Reference frame store.
    fdre_ram #(
        .WIDTH (fdre_pkg::WORD_W),
        .DEPTH (fdre_pkg::MAX_FRAME_WORDS)
    ) u_ref_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (take),
        .rd_addr (item.idx),
        .rd_data (ref_data)
    );

    // Compare, run accounting and record output.
    fdre_encode u_encode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .item_in  (item),
        .in_ready (enc_ready),
        .ref_data (ref_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ test/testbench.sv @@
// Testbench for the frame delta run encoder: directed and random frames checked by a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT     = 2000;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned WORDS_PER_PHASE = 56;
    localparam int unsigned MAX_REPORTS     = 40;
    localparam int unsigned NUM_PHASES      = 8;

    // Frame lengths per random phase, and the idle mix that each phase uses.
    localparam int unsigned PHASE_LEN [NUM_PHASES] = '{8, 1, 13, 0, 3, 32, 2, 5};
    localparam int unsigned SEND_IDLE [4]          = '{0, 55, 0, 18};
    localparam int unsigned RECV_STALL [4]         = '{0, 0, 55, 18};

    typedef struct {
        fdre_pkg::kind_t             kind;
        logic [fdre_pkg::WORD_W-1:0] value;
        logic                        last;
    } record_t;

    // Predicts the records of each accepted word and checks what comes out.
    class run_record_checker;
        logic [fdre_pkg::WORD_W-1:0]  ref_words [int unsigned];
        int unsigned                  frame_len;
        int unsigned                  word_index;
        bit                           run_open;
        logic [fdre_pkg::RUN_W-1:0]   run_len;
        logic [fdre_pkg::TOTAL_W-1:0] frame_total;
        record_t                      pending_records [$];
        int unsigned                  errors;

        function new();
            frame_len   = fdre_pkg::MAX_FRAME_WORDS;
            word_index  = 0;
            run_open    = 1'b0;
            run_len     = '0;
            frame_total = '0;
            errors      = 0;
        endfunction

        function int unsigned next_index();
            return (word_index >= fdre_pkg::MAX_FRAME_WORDS) ?
                   fdre_pkg::MAX_FRAME_WORDS - 1 : word_index;
        endfunction

        function bit is_loaded(int unsigned idx);
            return ref_words.exists(idx);
        endfunction

        function void set_frame_len(logic [fdre_pkg::CFG_W-1:0] value);
            frame_len = value;
        endfunction

        function void push(fdre_pkg::kind_t kind, logic [fdre_pkg::WORD_W-1:0] value,
                           logic last);
            record_t rec;
            rec.kind  = kind;
            rec.value = value;
            rec.last  = last;
            pending_records.push_back(rec);
        endfunction

        // Notes one accepted word and queues the records it must produce.
        function void accept_word(fdre_pkg::cmd_t cmd, logic [fdre_pkg::WORD_W-1:0] word);
            int unsigned span;
            int unsigned idx;
            bit          at_end;
            span = (frame_len == 0) ? 1 :
                   (frame_len > fdre_pkg::MAX_FRAME_WORDS) ? fdre_pkg::MAX_FRAME_WORDS :
                   frame_len;
            idx    = next_index();
            at_end = (idx >= span - 1);

            // A load fills the reference and throws away any open run and total.
            if (cmd == fdre_pkg::CMD_LOAD) begin
                ref_words[idx] = word;
                run_open       = 1'b0;
                run_len        = '0;
                frame_total    = '0;
                word_index     = at_end ? 0 : idx + 1;
                return;
            end

            if (ref_words[idx] != word) begin
                if (!run_open) begin
                    push(fdre_pkg::KIND_OFFSET,
                         fdre_pkg::WORD_W'(idx * fdre_pkg::BYTES_PER_WORD), 1'b0);
                    run_open    = 1'b1;
                    run_len     = '0;
                    frame_total = frame_total + fdre_pkg::TOTAL_W'(fdre_pkg::RUN_HDR_BYTES);
                end
                ref_words[idx] = word;
                push(fdre_pkg::KIND_DATA, word, 1'b0);
                run_len     = run_len + fdre_pkg::RUN_W'(fdre_pkg::BYTES_PER_WORD);
                frame_total = frame_total + fdre_pkg::TOTAL_W'(fdre_pkg::BYTES_PER_WORD);
                // A run still open on the last word closes there.
                if (at_end) begin
                    push(fdre_pkg::KIND_LENGTH, fdre_pkg::WORD_W'(run_len), 1'b0);
                    run_open = 1'b0;
                    run_len  = '0;
                end
            end else if (run_open) begin
                push(fdre_pkg::KIND_LENGTH, fdre_pkg::WORD_W'(run_len), 1'b0);
                run_open = 1'b0;
                run_len  = '0;
            end

            if (at_end) begin
                push(fdre_pkg::KIND_TOTAL, fdre_pkg::WORD_W'(frame_total), 1'b1);
                frame_total = '0;
                word_index  = 0;
            end else begin
                word_index = idx + 1;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("tb: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compares one record transfer with the oldest prediction.
        task check_record(logic [1:0] kind, logic [fdre_pkg::WORD_W-1:0] value, logic last);
            record_t want;
            if (pending_records.size() == 0) begin
                report($sformatf("unexpected record kind %0d value %h", kind, value));
                return;
            end
            want = pending_records.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, want %s", kind, want.kind.name()));
            if (value !== want.value)
                report($sformatf("%s value %h, want %h", want.kind.name(), value, want.value));
            if (last !== want.last)
                report($sformatf("%s last %b, want %b", want.kind.name(), last, want.last));
        endtask

        task check_drained();
            if (pending_records.size() != 0)
                report($sformatf("%0d records never arrived", pending_records.size()));
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [fdre_pkg::CFG_W-1:0]    cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [fdre_pkg::WORD_W-1:0]   s_tdata   = '0;  // [31:0] pixel_word
    logic                          s_tuser   = 1'b0; // [0] command
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [fdre_pkg::WORD_W-1:0]   m_tdata;         // [31:0] record_value
    logic [1:0]                    m_tuser;         // [1:0] record_kind
    logic                          m_tlast;

    run_record_checker   run_records;
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         holds_asked    = 0;
    int unsigned         holds_done     = 0;
    int unsigned         hold_left      = 0;
    int unsigned         quiet_cycles   = 0;
    bit                  changing       = 1'b0;

    frame_delta_run_encoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: check each transfer, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            run_records.check_record(m_tuser, m_tdata, m_tlast);
        if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Count cycles without any transfer on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // Offers one word after a random gap and returns at the edge that takes it.
    task automatic send_word(input fdre_pkg::cmd_t cmd,
                             input logic [fdre_pkg::WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        run_records.accept_word(cmd, word);
    endtask

    // Stops offering and waits until every predicted record has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (run_records.pending_records.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frame_len(input logic [fdre_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        run_records.set_frame_len(value);
    endtask

    function automatic logic [fdre_pkg::WORD_W-1:0] fresh_word(
        input logic [fdre_pkg::WORD_W-1:0] old);
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return old ^ (fdre_pkg::WORD_W'(1) << $urandom_range(fdre_pkg::WORD_W - 1));
            default: return $urandom;
        endcase
    endfunction

    // Loads where the reference is still empty, otherwise mostly encodes runs.
    task automatic send_random_word();
        int unsigned idx;
        idx = run_records.next_index();
        if (!run_records.is_loaded(idx) || $urandom_range(99) < 4) begin
            send_word(fdre_pkg::CMD_LOAD, fresh_word($urandom));
        end else begin
            if ($urandom_range(99) < 30)
                changing = !changing;
            if (changing)
                send_word(fdre_pkg::CMD_ENCODE, fresh_word(run_records.ref_words[idx]));
            else
                send_word(fdre_pkg::CMD_ENCODE, run_records.ref_words[idx]);
        end
    endtask

    initial begin
        run_records = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the first words at the full frame length.
        send_word(fdre_pkg::CMD_LOAD, 32'h0000_0000);
        send_word(fdre_pkg::CMD_LOAD, 32'hFFFF_FFFF);
        send_word(fdre_pkg::CMD_LOAD, 32'h0000_0000);
        send_word(fdre_pkg::CMD_LOAD, 32'hFFFF_FFFF);

        // Shrink the frame: the next load sits past the end and wraps.
        write_frame_len(fdre_pkg::CFG_W'(4));
        send_word(fdre_pkg::CMD_LOAD, 32'h8000_0001);

        // Two runs, the second one closed by the frame end.
        send_word(fdre_pkg::CMD_ENCODE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::CMD_ENCODE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0001);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0000);

        // Last word opens a run and closes the frame: four records at once.
        send_word(fdre_pkg::CMD_ENCODE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0000);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0001);
        send_word(fdre_pkg::CMD_ENCODE, 32'hFFFF_FFFF);

        // Leave a run open mid-frame, then a zero length puts the index past the end.
        send_word(fdre_pkg::CMD_ENCODE, 32'hFFFF_FFFF);
        send_word(fdre_pkg::CMD_ENCODE, 32'h7FFF_FFFF);
        write_frame_len(fdre_pkg::CFG_W'(0));
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0001);

        // One-word frames: a full run, an unchanged word, a load.
        send_word(fdre_pkg::CMD_ENCODE, 32'h8000_0000);
        send_word(fdre_pkg::CMD_ENCODE, 32'h8000_0000);
        send_word(fdre_pkg::CMD_LOAD, 32'h0000_0000);

        // Oversized length acts as the store size; a load drops the open run.
        write_frame_len('1);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0000);
        send_word(fdre_pkg::CMD_ENCODE, 32'h7FFF_FFFF);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0002);
        send_word(fdre_pkg::CMD_ENCODE, 32'h0000_0000);
        send_word(fdre_pkg::CMD_LOAD, 32'h0000_0000);
        write_frame_len(fdre_pkg::CFG_W'(5));
        send_word(fdre_pkg::CMD_LOAD, 32'h5A5A_5A5A);

        // Random frames over several lengths and idle mixes.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_frame_len(fdre_pkg::CFG_W'(PHASE_LEN[p]));
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                // Hold the result side off so the block fills and stalls its input.
                if (p == 4 && i == 20)
                    holds_asked++;
                send_random_word();
            end
        end

        recv_stall_pct = 0;
        wait_drained();
        repeat (20) @(posedge aclk);
        run_records.check_drained();
        if (run_records.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fdre_pkg.sv
hw/rtl/fdre_ram.sv
hw/rtl/fdre_index.sv
hw/rtl/fdre_encode.sv
hw/rtl/frame_delta_run_encoder_top.sv
test/testbench.sv
